### rtl/core/trsa_pkg.sv
package trsa_pkg;

    localparam int TICK_W    = 64;
    localparam int SLOT_W    = 6;
    localparam int SIZE_W    = 7;
    localparam int STEP_W    = 7;
    localparam int ADDR_W    = 2;
    localparam int DATA_W    = 32;
    localparam int MAX_SLOTS = 64;

    localparam logic [SIZE_W-1:0] POOL_MAX       = SIZE_W'(MAX_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST      = SLOT_W'(MAX_SLOTS - 1);
    localparam logic [STEP_W-1:0] GROW_INC_RESET = STEP_W'(4);

    // register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_GROW_INC = ADDR_W'(0);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // control from the sequencer to the ring of slot cells
    typedef struct packed {
        logic              shift;
        logic              load;
        logic [SLOT_W-1:0] load_slot;
    } t_ring_ctl;

endpackage

### rtl/core/trsa_cell.sv
module trsa_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic                        i_load,
    input  logic [trsa_pkg::TICK_W-1:0] i_shift_tick,
    input  logic [trsa_pkg::TICK_W-1:0] i_load_tick,
    output logic [trsa_pkg::TICK_W-1:0] o_tick
);

    logic [trsa_pkg::TICK_W-1:0] r_tick;

    // stamp has priority over the rotation, they never coincide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (i_load) begin
            r_tick <= i_load_tick;
        end else if (i_shift) begin
            r_tick <= i_shift_tick;
        end
    end

    assign o_tick = r_tick;

endmodule

### rtl/core/trsa_ring.sv
module trsa_ring (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  trsa_pkg::t_ring_ctl         i_ctl,
    input  logic [trsa_pkg::TICK_W-1:0] i_load_tick,
    output logic [trsa_pkg::TICK_W-1:0] o_head_tick
);

    logic [trsa_pkg::TICK_W-1:0] w_tick [trsa_pkg::MAX_SLOTS];

    // cell k takes from cell k+1, the last cell takes from the head
    for (genvar k = 0; k < trsa_pkg::MAX_SLOTS; k++) begin : g_cell
        logic w_load;

        assign w_load = i_ctl.load &&
                        (i_ctl.load_slot == trsa_pkg::SLOT_W'(k));

        trsa_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (i_ctl.shift),
            .i_load       (w_load),
            .i_shift_tick (w_tick[(k + 1) % trsa_pkg::MAX_SLOTS]),
            .i_load_tick  (i_load_tick),
            .o_tick       (w_tick[k])
        );
    end

    assign o_head_tick = w_tick[0];

endmodule

### rtl/core/tick_ring_slot_allocator.sv
// next-fit circular slot allocator over a ring of 64 tick cells
//
// request channel: the done tick (latest completed tick) and current_tick are
// taken at a rising edge with start high and busy low. one result follows
// per request on o_slot / o_grew / o_full_res, shown for exactly one cycle
// with o_valid high; the receiver has no way to stall it.
// sequence: a request passes through a scan of the whole ring, then a commit
// and then the result; busy stays high through scan and commit. a new
// request may be accepted in the cycle the result is shown, so the block
// handles one request at a time. the scan length is set by the ring: the
// stored ticks rotate one cell per scan cycle past a single comparator at the
// head, and a full turn realigns the ring so slot k sits in cell k again.
// configuration: apb port, grow increment at byte address 0; the user writes it
// only while idle, the block does not check. prdata returns it, pready tied high.
// reset (synchronous, active low): all ticks zero, pool empty, hint zero,
// grow increment 4.
module tick_ring_slot_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic [trsa_pkg::TICK_W-1:0]   i_done_tick,
    input  logic [trsa_pkg::TICK_W-1:0]   i_current_tick,
    // result channel
    output logic                          o_valid,
    output logic [trsa_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_grew,
    output logic                          o_full_res,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trsa_pkg::ADDR_W-1:0]   paddr,
    input  logic [trsa_pkg::DATA_W-1:0]   pwdata,
    output logic [trsa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    trsa_pkg::t_state r_state;
    trsa_pkg::t_state n_state;

    // architectural state
    logic [trsa_pkg::SIZE_W-1:0] r_pool;
    logic [trsa_pkg::SLOT_W-1:0] r_hint;
    logic [trsa_pkg::STEP_W-1:0] r_grow_inc;

    // per-request working registers
    logic [trsa_pkg::TICK_W-1:0] r_done;
    logic [trsa_pkg::TICK_W-1:0] r_now;
    logic [trsa_pkg::SLOT_W-1:0] r_start_hint;
    logic [trsa_pkg::SLOT_W-1:0] r_cnt;
    logic                        r_found;
    logic [trsa_pkg::SLOT_W-1:0] r_best_idx;
    logic [trsa_pkg::SIZE_W-1:0] r_best_rank;

    // result registers
    logic                        r_valid;
    logic [trsa_pkg::SLOT_W-1:0] r_slot;
    logic                        r_grew;
    logic                        r_full;

    trsa_pkg::t_ring_ctl          w_ctl;
    logic [trsa_pkg::TICK_W-1:0]  w_head_tick;
    logic                         w_accept;
    logic                         w_cfg_wr;

    // scan-side signals
    logic                         w_cand;
    logic [trsa_pkg::SIZE_W-1:0]  w_rank;

    // commit-side signals
    logic [trsa_pkg::STEP_W-1:0]  w_step;
    logic [trsa_pkg::SIZE_W:0]    w_sum;
    logic [trsa_pkg::SIZE_W-1:0]  w_new_pool;
    logic                         w_full;
    logic                         w_grew;
    logic [trsa_pkg::SLOT_W-1:0]  w_chosen;
    logic [trsa_pkg::SIZE_W-1:0]  w_chosen_inc;

    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // the single register sits at address zero
    always_comb begin
        prdata = '0;
        if (paddr == trsa_pkg::ADDR_GROW_INC) begin
            prdata = trsa_pkg::DATA_W'(r_grow_inc);
        end
    end

    trsa_ring u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_load_tick (r_now),
        .o_head_tick (w_head_tick)
    );

    // the ring rotates once per scan cycle, so the head holds slot r_cnt.
    // slots at or above the pool size are never stamped and stay zero, so
    // growth needs no clearing; they are just left out of the scan.
    assign w_cand = ({1'b0, r_cnt} < r_pool) && (r_done >= w_head_tick);

    // circular distance from the hint within the pool sets scan order
    always_comb begin
        if (r_cnt >= r_start_hint) begin
            w_rank = {1'b0, r_cnt} - {1'b0, r_start_hint};
        end else begin
            w_rank = {1'b0, r_cnt} + r_pool - {1'b0, r_start_hint};
        end
    end

    // commit decision: reuse the found slot, else grow, else report full
    assign w_step = (r_grow_inc == '0) ? trsa_pkg::STEP_W'(1) : r_grow_inc;
    assign w_sum  = {1'b0, r_pool} + (trsa_pkg::SIZE_W + 1)'(w_step);

    always_comb begin
        w_full     = 1'b0;
        w_grew     = 1'b0;
        w_chosen   = r_best_idx;
        w_new_pool = r_pool;
        if (!r_found) begin
            if (r_pool >= trsa_pkg::POOL_MAX) begin
                w_full   = 1'b1;
                w_chosen = '0;
            end else begin
                w_grew   = 1'b1;
                w_chosen = r_pool[trsa_pkg::SLOT_W-1:0];
                if (w_sum > (trsa_pkg::SIZE_W + 1)'(trsa_pkg::POOL_MAX)) begin
                    w_new_pool = trsa_pkg::POOL_MAX;
                end else begin
                    w_new_pool = w_sum[trsa_pkg::SIZE_W-1:0];
                end
            end
        end
    end

    assign w_chosen_inc = {1'b0, w_chosen} + trsa_pkg::SIZE_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            trsa_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = trsa_pkg::ST_SCAN;
                end
            end
            trsa_pkg::ST_SCAN: begin
                if (r_cnt == trsa_pkg::SLOT_LAST) begin
                    n_state = trsa_pkg::ST_COMMIT;
                end
            end
            trsa_pkg::ST_COMMIT: begin
                n_state = trsa_pkg::ST_IDLE;
            end
            default: begin
                n_state = trsa_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        busy            = 1'b1;
        w_ctl.shift     = 1'b0;
        w_ctl.load      = 1'b0;
        w_ctl.load_slot = w_chosen;
        unique case (r_state)
            trsa_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            trsa_pkg::ST_SCAN: begin
                w_ctl.shift = 1'b1;
            end
            trsa_pkg::ST_COMMIT: begin
                w_ctl.load = !w_full;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= trsa_pkg::ST_IDLE;
            r_pool     <= '0;
            r_hint     <= '0;
            r_grow_inc <= trsa_pkg::GROW_INC_RESET;
            r_cnt      <= '0;
            r_found    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == trsa_pkg::ST_COMMIT);

            if (w_cfg_wr && paddr == trsa_pkg::ADDR_GROW_INC) begin
                r_grow_inc <= pwdata[trsa_pkg::STEP_W-1:0];
            end

            if (w_accept) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (r_state == trsa_pkg::ST_SCAN) begin
                r_cnt <= r_cnt + trsa_pkg::SLOT_W'(1);
                if (w_cand) begin
                    r_found <= 1'b1;
                end
            end

            if (r_state == trsa_pkg::ST_COMMIT && !w_full) begin
                r_pool <= w_new_pool;
                if (w_chosen_inc == w_new_pool) begin
                    r_hint <= '0;
                end else begin
                    r_hint <= w_chosen_inc[trsa_pkg::SLOT_W-1:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_done <= i_done_tick;
            r_now  <= i_current_tick;
            // a hint at or beyond the pool size restarts the scan at slot zero
            if ({1'b0, r_hint} >= r_pool) begin
                r_start_hint <= '0;
            end else begin
                r_start_hint <= r_hint;
            end
        end
        if (r_state == trsa_pkg::ST_SCAN && w_cand &&
            (!r_found || w_rank < r_best_rank)) begin
            r_best_idx  <= r_cnt;
            r_best_rank <= w_rank;
        end
        if (r_state == trsa_pkg::ST_COMMIT) begin
            r_slot <= w_chosen;
            r_grew <= w_grew;
            r_full <= w_full;
        end
    end

    assign o_valid    = r_valid;
    assign o_slot     = r_slot;
    assign o_grew     = r_grew;
    assign o_full_res = r_full;

endmodule

### dv/tb_tick_ring_slot_allocator.sv
`timescale 1ns / 1ps

module tb_tick_ring_slot_allocator;

    // longest stretch with no request and no result a correct run can show:
    // a sender gap or one full scan and commit, well below this limit
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [trsa_pkg::TICK_W-1:0] TICK_ONES = {trsa_pkg::TICK_W{1'b1}};

    typedef struct packed {
        logic [trsa_pkg::SLOT_W-1:0] slot;
        logic                        grew;
        logic                        full;
    } t_alloc_result;

    // dut connections, all inputs known from time zero
    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [trsa_pkg::TICK_W-1:0] req_done_tick = '0;
    logic [trsa_pkg::TICK_W-1:0] current_tick = '0;
    logic                        res_valid;
    logic [trsa_pkg::SLOT_W-1:0] res_slot;
    logic                        res_grew;
    logic                        res_full;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [trsa_pkg::ADDR_W-1:0] paddr = '0;
    logic [trsa_pkg::DATA_W-1:0] pwdata = '0;
    logic [trsa_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    // shadow allocator state
    logic [trsa_pkg::TICK_W-1:0] slot_ticks [trsa_pkg::MAX_SLOTS];
    int                          pool_count;
    int                          scan_hint;
    logic [trsa_pkg::STEP_W-1:0] grow_cfg;

    // allocations predicted but not yet seen on the result port
    t_alloc_result               pending_allocs [$];

    int                          error_count = 0;
    int                          quiet_cycles = 0;
    int                          burst_left = 0;
    logic [trsa_pkg::TICK_W-1:0] tick_now = 64'd100;

    tick_ring_slot_allocator DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_done_tick    (req_done_tick),
        .i_current_tick (current_tick),
        .o_valid        (res_valid),
        .o_slot         (res_slot),
        .o_grew         (res_grew),
        .o_full_res     (res_full),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // next-fit allocation on the shadow state: circular scan from the hint,
    // grow when nothing is free, report full once the pool is at its maximum
    function automatic t_alloc_result predict_allocation(
            input logic [trsa_pkg::TICK_W-1:0] done_tick,
            input logic [trsa_pkg::TICK_W-1:0] stamp_tick);
        t_alloc_result res;
        int            first;
        int            pick;
        int            idx;
        int            step;
        int            new_count;
        first = (scan_hint >= pool_count) ? 0 : scan_hint;
        pick = -1;
        res = '0;
        for (int k = 0; k < pool_count; k++) begin
            idx = (first + k) % pool_count;
            if (pick < 0 && done_tick >= slot_ticks[idx])
                pick = idx;
        end
        if (pick < 0) begin
            if (pool_count >= trsa_pkg::MAX_SLOTS) begin
                // pool exhausted: no state change at all
                res.full = 1'b1;
                return res;
            end
            // a zero step behaves as one, oversize steps clamp at the maximum
            step = (grow_cfg == '0) ? 1 : int'(grow_cfg);
            new_count = pool_count + step;
            if (new_count > trsa_pkg::MAX_SLOTS)
                new_count = trsa_pkg::MAX_SLOTS;
            for (int k = pool_count; k < new_count; k++)
                slot_ticks[k] = '0;
            pick = pool_count;
            pool_count = new_count;
            res.grew = 1'b1;
        end
        slot_ticks[pick] = stamp_tick;
        scan_hint = (pick + 1) % pool_count;
        res.slot = trsa_pkg::SLOT_W'(pick);
        return res;
    endfunction

    // present one request and hold it until taken; the sender then keeps
    // start high for the next one or drops it for a random gap
    task automatic send_request(input logic [trsa_pkg::TICK_W-1:0] done_tick,
                                input logic [trsa_pkg::TICK_W-1:0] stamp_tick);
        int gap;
        start         <= 1'b1;
        req_done_tick <= done_tick;
        current_tick  <= stamp_tick;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_allocs.push_back(predict_allocation(done_tick, stamp_tick));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // drop start and wait until every request has produced its result
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_allocs.size() != 0)
            @(posedge clk);
    endtask

    // apb write of the grow increment followed by a read back
    task automatic set_grow_inc(input logic [trsa_pkg::DATA_W-1:0] value);
        logic [trsa_pkg::DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= trsa_pkg::ADDR_GROW_INC;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        grow_cfg = value[trsa_pkg::STEP_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== trsa_pkg::DATA_W'(grow_cfg)) begin
            $display("%0t grow increment read back: expected %0d actual %0d",
                     $realtime, grow_cfg, readback);
            error_count++;
        end
    endtask

    // random request content: the completed tick is half the time a little behind
    // the running tick so that some slots are free and some are not
    task automatic random_request();
        logic [trsa_pkg::TICK_W-1:0] done_tick;
        logic [trsa_pkg::TICK_W-1:0] stamp_tick;
        int                          lag;
        tick_now += $urandom_range(1, 5);
        case ($urandom_range(0, 9))
            5, 6:    done_tick = '0;
            7:       done_tick = TICK_ONES;
            8, 9:    done_tick = {$urandom, $urandom};
            default: begin
                lag = $urandom_range(0, 80);
                done_tick = (tick_now > lag) ? tick_now - lag : '0;
            end
        endcase
        case ($urandom_range(0, 31))
            0:       stamp_tick = '0;
            1:       stamp_tick = TICK_ONES;
            2, 3:    stamp_tick = {$urandom, $urandom};
            default: stamp_tick = tick_now;
        endcase
        send_request(done_tick, stamp_tick);
    endtask

    // first request on an empty pool grows it by the reset step of 4,
    // then the pool is used up and grows again
    task automatic test_empty_pool_growth();
        send_request(64'd0, 64'd10);
        send_request(64'd0, 64'd11);
        send_request(64'd0, 64'd12);
        send_request(64'd0, 64'd13);
        send_request(64'd9, 64'd14);
        send_request(TICK_ONES, 64'd15);
        wait_idle();
    endtask

    // zero step acts as one, then explicit steps of one and three
    task automatic test_grow_inc_values();
        set_grow_inc(32'd0);
        send_request(64'd0, 64'd16);
        send_request(64'd0, 64'd17);
        send_request(64'd0, 64'd18);
        wait_idle();
        set_grow_inc(32'd1);
        send_request(64'd0, TICK_ONES);
        send_request(TICK_ONES - 64'd1, 64'd20);
        wait_idle();
        set_grow_inc(32'd3);
        send_request(64'd5, 64'd21);
        send_request(64'd5, 64'd22);
        send_request(64'd5, 64'd23);
        wait_idle();
    endtask

    // the largest step overshoots and the pool stops at its maximum
    task automatic test_growth_saturation();
        set_grow_inc(32'd127);
        send_request(64'd5, 64'd24);
        send_request(64'd0, 64'd25);
        send_request(64'd24, 64'd26);
        wait_idle();
    endtask

    // random traffic in phases, each under a new grow increment
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            set_grow_inc({$urandom_range(0, 1) ? $urandom : 32'd0} ^
                         trsa_pkg::DATA_W'(phase * 40));
            repeat (230)
                random_request();
            wait_idle();
        end
    endtask

    // only slots holding a zero tick are free at a completed tick of zero, so these
    // requests use them all up and then keep hitting the full pool
    task automatic test_pool_full();
        set_grow_inc(32'd64);
        repeat (70) begin
            tick_now += $urandom_range(1, 5);
            send_request(64'd0, tick_now);
        end
        wait_idle();
    endtask

    // result check, sampled at the edge that ends the result cycle
    always @(posedge clk) begin
        t_alloc_result want;
        if (rst_n && res_valid) begin
            if (pending_allocs.size() == 0) begin
                $display("%0t unexpected result: expected none actual slot %0d grew %0b full %0b",
                         $realtime, res_slot, res_grew, res_full);
                error_count++;
            end else begin
                want = pending_allocs[0];
                pending_allocs.delete(0);
                if (res_slot !== want.slot) begin
                    $display("%0t slot mismatch: expected %0d actual %0d",
                             $realtime, want.slot, res_slot);
                    error_count++;
                end
                if (res_grew !== want.grew) begin
                    $display("%0t grew mismatch: expected %0b actual %0b",
                             $realtime, want.grew, res_grew);
                    error_count++;
                end
                if (res_full !== want.full) begin
                    $display("%0t full_res mismatch: expected %0b actual %0b",
                             $realtime, want.full, res_full);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles where neither a request nor a result is taken and no register access runs
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || res_valid || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t watchdog expired with %0d results outstanding",
                     $realtime, pending_allocs.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int k = 0; k < trsa_pkg::MAX_SLOTS; k++)
            slot_ticks[k] = '0;
        pool_count = 0;
        scan_hint  = 0;
        grow_cfg   = trsa_pkg::GROW_INC_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pool_growth();
        test_grow_inc_values();
        test_growth_saturation();
        test_random_traffic();
        test_pool_full();

        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
rtl/core/trsa_pkg.sv
rtl/core/trsa_cell.sv
rtl/core/trsa_ring.sv
rtl/core/tick_ring_slot_allocator.sv
dv/tb_tick_ring_slot_allocator.sv
